// ===== design/fptw_pkg.sv =====
// Shared types, constants and helpers for the four-level page-table walker.
`default_nettype none
package fptw_pkg;

    localparam int PFN_W      = 40;
    localparam int VA_W       = 48;
    localparam int PA_W       = 52;
    localparam int PERM_W     = 12;
    localparam int ENTRY_W    = 64;
    localparam int IDX_W      = 9;
    localparam int OFFS_W     = 12;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;

    // remainder unit: bits folded per cycle and number of folding steps per reduction
    localparam int MOD_STEP   = 8;
    localparam int MOD_STEPS  = PFN_W / MOD_STEP;

    localparam logic [PERM_W-1:0] PERM_GLOBAL = 12'h100;

    localparam logic CMD_XLATE = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] LVL_LEAF = 2'd3;
    localparam logic [1:0] LVL_LAST_UPPER = 2'd2;

    // register select is paddr bit 3 (64-bit registers at 8-byte strides)
    localparam logic REG_POOL_BASE = 1'b0;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_CHK   = 7'b0001000,
        S_MOD   = 7'b0010000,
        S_ALLOC = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // table index of a virtual address at a walk level (0 = root)
    function automatic logic [IDX_W-1:0] va_idx(input logic [VA_W-1:0] va,
                                                input logic [1:0] lvl);
        logic [IDX_W-1:0] r;
        case (lvl)
            2'd0:    r = va[47:39];
            2'd1:    r = va[38:30];
            2'd2:    r = va[29:21];
            default: r = va[20:12];
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/fptw_mod.sv =====
// Reduces a relative frame number modulo the pool size.
`default_nettype none
module fptw_mod
    import fptw_pkg::*;
#(
    parameter int TABLE_FRAMES = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [PFN_W-1:0]                  i_rel,
    output logic                                   o_done,
    output logic [$clog2(TABLE_FRAMES)-1:0]        o_index
);

    localparam int  FW      = $clog2(TABLE_FRAMES);
    localparam bit  IS_POW2 = (TABLE_FRAMES & (TABLE_FRAMES - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic          r_done;
            logic [FW-1:0] r_idx;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_idx <= i_rel[FW-1:0];
                end
            end

            assign o_done  = r_done;
            assign o_index = r_idx;
        end else begin : g_serial
            localparam logic [FW:0] NMOD = (FW + 1)'(TABLE_FRAMES);

            logic             r_busy;
            logic             r_done;
            logic [2:0]       r_cnt;
            logic [PFN_W-1:0] r_sh;
            logic [FW:0]      r_rem;
            logic [FW:0]      n_rem;

            // restoring remainder, MOD_STEP bits per cycle, MSB first
            always_comb begin
                logic [FW:0] t;
                t = r_rem;
                for (int k = 0; k < MOD_STEP; k++) begin
                    t = {t[FW-1:0], r_sh[PFN_W-1-k]};
                    if (t >= NMOD) begin
                        t = t - NMOD;
                    end
                end
                n_rem = t;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                    end else if (r_busy && r_cnt == 3'(MOD_STEPS - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_sh  <= i_rel;
                    r_rem <= '0;
                    r_cnt <= '0;
                end else if (r_busy) begin
                    r_sh  <= r_sh << MOD_STEP;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 3'd1;
                end
            end

            assign o_done  = r_done;
            assign o_index = r_rem[FW-1:0];
        end
    endgenerate

endmodule
`default_nettype wire

// ===== design/fptw_store.sv =====
// Single-port table store with registered read data.
`default_nettype none
module fptw_store
    import fptw_pkg::*;
#(
    parameter int TABLE_FRAMES = 16
) (
    input  wire logic                                  i_clk,
    input  wire t_mem_ctl                              i_ctl,
    input  wire logic [$clog2(TABLE_FRAMES)+IDX_W-1:0] i_addr,
    input  wire logic [ENTRY_W-1:0]                    i_wdata,
    output logic [ENTRY_W-1:0]                         o_rdata
);

    localparam int DEPTH = TABLE_FRAMES * (1 << IDX_W);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/four_level_page_table_walker.sv =====
// Four-level page-table walker: sequencer, config register and result register.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_cmd, i_virt_addr, i_phys_addr, i_perm
//  output    out        o_valid / i_ready    o_value, o_status
//  config    in         APB psel/penable     paddr, pwdata, prdata (pool_base_frame)
//
// One item at a time. Each table level takes a read state and a check state on the
// single store port; following a pointer also waits in S_MOD on the remainder unit
// (a mask when TABLE_FRAMES is a power of two, else a serial MOD_STEP-bit reduction).
// A map that finds a level missing stops walking there and writes one pointer entry
// per fresh frame before it reads the leaf.
// After reset the store is swept to zero with o_ready low.
// A finished result waits in the output register; the next item is taken meanwhile.
`default_nettype none
module four_level_page_table_walker
    import fptw_pkg::*;
#(
    parameter int TABLE_FRAMES = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_cmd,
    input  wire logic [VA_W-1:0]       i_virt_addr,
    input  wire logic [PA_W-1:0]       i_phys_addr,
    input  wire logic [PERM_W-1:0]     i_perm,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [ENTRY_W-1:0]         o_value,
    output logic [1:0]                 o_status,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int FW    = $clog2(TABLE_FRAMES);
    localparam int AW    = FW + IDX_W;
    localparam int NFW   = $clog2(TABLE_FRAMES + 1);
    localparam int DEPTH = TABLE_FRAMES * (1 << IDX_W);

    t_state             r_state, n_state;
    logic               r_cmd;
    logic [VA_W-1:0]    r_va;
    logic [PA_W-1:0]    r_pa;
    logic [PERM_W-1:0]  r_perm;
    logic [1:0]         r_lvl, n_lvl;
    logic [FW-1:0]      r_frame, n_frame;
    logic [NFW-1:0]     r_nf, n_nf;
    logic [AW-1:0]      r_clr, n_clr;
    logic [PFN_W-1:0]   r_base;
    logic [ENTRY_W-1:0] r_res_value, n_res_value;
    logic [1:0]         r_res_status, n_res_status;
    logic               r_o_valid, n_o_valid;
    logic [ENTRY_W-1:0] r_o_value;
    logic [1:0]         r_o_status;

    t_mem_ctl           mem_ctl;
    logic [AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;

    logic               mod_start;
    logic [PFN_W-1:0]   mod_rel;
    logic               mod_done;
    logic [FW-1:0]      mod_index;

    logic               in_fire;
    logic               cfg_wr;
    logic [PFN_W-1:0]   new_pfn;
    logic [NFW-1:0]     avail;
    logic [NFW-1:0]     needed;

    assign in_fire = i_valid && o_ready;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[3] == REG_POOL_BASE);
    assign new_pfn = r_base + PFN_W'(r_nf);
    assign avail   = NFW'(TABLE_FRAMES) - r_nf;
    assign needed  = NFW'(LVL_LEAF - r_lvl);
    assign mod_rel = mem_rdata[51:12] - r_base;

    fptw_store #(.TABLE_FRAMES(TABLE_FRAMES)) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    fptw_mod #(.TABLE_FRAMES(TABLE_FRAMES)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_rel   (mod_rel),
        .o_done  (mod_done),
        .o_index (mod_index)
    );

    always_comb begin
        n_state      = r_state;
        n_lvl        = r_lvl;
        n_frame      = r_frame;
        n_nf         = r_nf;
        n_clr        = r_clr;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_o_valid    = r_o_valid && !i_ready;
        mem_ctl      = '0;
        mem_addr     = {r_frame, va_idx(r_va, r_lvl)};
        mem_wdata    = '0;
        mod_start    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_ctl.wr = 1'b1;
                mem_addr   = r_clr;
                n_clr      = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_lvl   = '0;
                    n_frame = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                mem_ctl.rd = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (r_lvl == LVL_LEAF) begin
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                    if (r_cmd == CMD_MAP) begin
                        // old leaf out, new leaf in at the same slot
                        n_res_value = mem_rdata;
                        mem_ctl.wr  = 1'b1;
                        mem_wdata   = {12'b0, r_pa} | ENTRY_W'(r_perm);
                    end else begin
                        n_res_value = {12'b0, mem_rdata[51:12], r_va[OFFS_W-1:0]};
                    end
                end else if (!mem_rdata[0]) begin
                    if (r_cmd == CMD_XLATE) begin
                        n_res_value  = '1;
                        n_res_status = ST_MISS;
                        n_state      = S_DONE;
                    end else if (needed > avail) begin
                        n_res_value  = '0;
                        n_res_status = ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end else begin
                    mod_start = 1'b1;
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_frame = mod_index;
                    n_lvl   = r_lvl + 2'd1;
                    n_state = S_RD;
                end
            end
            S_ALLOC: begin
                mem_ctl.wr = 1'b1;
                mem_wdata  = {12'b0, new_pfn, 12'b0}
                           | ENTRY_W'(r_perm & ~PERM_GLOBAL) | ENTRY_W'(1);
                n_frame    = r_nf[FW-1:0];
                n_nf       = r_nf + NFW'(1);
                n_lvl      = r_lvl + 2'd1;
                if (r_lvl == LVL_LAST_UPPER) begin
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_nf      <= NFW'(1);
            r_o_valid <= 1'b0;
            r_base    <= '0;
            r_lvl     <= '0;
            r_frame   <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_nf      <= n_nf;
            r_o_valid <= n_o_valid;
            r_lvl     <= n_lvl;
            r_frame   <= n_frame;
            if (cfg_wr) begin
                r_base <= pwdata[PFN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        if (in_fire) begin
            r_cmd  <= i_cmd;
            r_va   <= i_virt_addr;
            r_pa   <= i_phys_addr;
            r_perm <= i_perm;
        end
        if (r_state == S_DONE && (!r_o_valid || i_ready)) begin
            r_o_value  <= r_res_value;
            r_o_status <= r_res_status;
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_o_valid;
    assign o_value  = r_o_value;
    assign o_status = r_o_status;
    assign pready   = 1'b1;
    assign prdata   = (paddr[3] == REG_POOL_BASE) ? CFG_DATA_W'(r_base) : '0;

endmodule
`default_nettype wire

// ===== design/fptw_chk.sv =====
// Port-level checks for the page-table walker, bound to the top level.
`default_nettype none
module fptw_chk
    import fptw_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic [ENTRY_W-1:0] o_value,
    input wire logic [1:0]         o_status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_status))
        else $error("result changed while stalled");

    // a miss always reports all ones
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_MISS |-> o_value == '1)
        else $error("miss without all-ones value");

    // exhausted pool reports zero
    a_full_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_value == '0)
        else $error("pool-full result not zero");

    // reset starts the clearing sweep: nothing taken, nothing shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("ready or valid right after reset");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken while walking");

endmodule

bind four_level_page_table_walker fptw_chk u_fptw_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_value  (o_value),
    .o_status (o_status)
);
`default_nettype wire

// ===== bench/four_level_page_table_walker_tb.sv =====
// Self-checking bench for the page-table walker: directed walks, then random map/translate traffic.
module four_level_page_table_walker_tb;
    import fptw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_FRAMES = 16;
    localparam int ENTRIES      = 512;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 305;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic [CFG_ADDR_W-1:0] POOL_BASE_ADDR = {REG_POOL_BASE, 3'b000};

    typedef struct packed {
        logic              cmd;
        logic [VA_W-1:0]   va;
        logic [PA_W-1:0]   pa;
        logic [PERM_W-1:0] perm;
    } t_walk_req;

    typedef struct packed {
        logic [ENTRY_W-1:0] value;
        logic [1:0]         status;
    } t_walk_rsp;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_cmd = CMD_XLATE;
    logic [VA_W-1:0]       i_virt_addr = '0;
    logic [PA_W-1:0]       i_phys_addr = '0;
    logic [PERM_W-1:0]     i_perm = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [ENTRY_W-1:0]    o_value;
    logic [1:0]            o_status;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    four_level_page_table_walker #(.TABLE_FRAMES(TABLE_FRAMES)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_virt_addr(i_virt_addr), .i_phys_addr(i_phys_addr), .i_perm(i_perm),
        .o_valid(o_valid), .i_ready(i_ready), .o_value(o_value), .o_status(o_status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6ns i_clk = ~i_clk;

    // shadow copy of the table pool and allocator
    logic [ENTRY_W-1:0] page_tables [TABLE_FRAMES*ENTRIES];
    int unsigned        next_frame;
    logic [PFN_W-1:0]   pool_base;

    t_walk_req          pending_req [$];
    t_walk_rsp          expected_rsp [$];
    logic [VA_W-1:0]    mapped_va [$];
    t_walk_req          drv_item;
    int unsigned        req_gap = 0;
    int unsigned        rsp_stall = 0;
    int unsigned        stall_len;
    int unsigned        cycle_cnt = 0;
    int                 err_cnt = 0;
    logic               no_idle = 1'b0;

    function automatic int unsigned slot(input int unsigned frame, input logic [IDX_W-1:0] idx);
        return (frame % TABLE_FRAMES) * ENTRIES + idx;
    endfunction

    // pointer -> pool frame, wrapping relative to the current base
    function automatic int unsigned frame_of(input logic [ENTRY_W-1:0] e);
        logic [PFN_W-1:0] rel;
        rel = e[51:12] - pool_base;
        return 32'(rel % PFN_W'(TABLE_FRAMES));
    endfunction

    function automatic t_walk_rsp walk_predict(input t_walk_req r);
        logic [IDX_W-1:0] idx [4];
        int unsigned      frame;
        int unsigned      lvl;
        int unsigned      needed;
        int unsigned      avail;
        int unsigned      nf;
        int unsigned      s;
        logic [ENTRY_W-1:0] e;
        logic [PFN_W-1:0] pfn;
        t_walk_rsp        rsp;
        for (int k = 0; k < 4; k++) idx[k] = r.va[47 - 9*k -: 9];
        frame = 0;
        if (r.cmd == CMD_XLATE) begin
            for (lvl = 0; lvl < 3; lvl++) begin
                e = page_tables[slot(frame, idx[lvl])];
                if (!e[0]) begin
                    rsp.value  = '1;
                    rsp.status = ST_MISS;
                    return rsp;
                end
                frame = frame_of(e);
            end
            // leaf present bit deliberately ignored
            e = page_tables[slot(frame, idx[3])];
            rsp.value  = {12'b0, e[51:12], r.va[11:0]};
            rsp.status = ST_OK;
            return rsp;
        end
        lvl = 0;
        while (lvl < 3 && page_tables[slot(frame, idx[lvl])][0]) begin
            frame = frame_of(page_tables[slot(frame, idx[lvl])]);
            lvl++;
        end
        needed = 3 - lvl;
        avail  = (next_frame < TABLE_FRAMES) ? TABLE_FRAMES - next_frame : 0;
        if (needed > avail) begin
            rsp.value  = '0;
            rsp.status = ST_FULL;
            return rsp;
        end
        while (lvl < 3) begin
            nf  = next_frame;
            pfn = pool_base + PFN_W'(nf);
            next_frame++;
            page_tables[slot(frame, idx[lvl])] =
                {12'b0, pfn, 12'b0} | 64'd1 | {52'b0, r.perm & ~PERM_GLOBAL};
            frame = nf;
            lvl++;
        end
        s = slot(frame, idx[3]);
        rsp.value      = page_tables[s];
        page_tables[s] = {12'b0, r.pa} | {52'b0, r.perm};
        rsp.status     = ST_OK;
        return rsp;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_item(input logic cmd, input logic [VA_W-1:0] va,
                            input logic [PA_W-1:0] pa, input logic [PERM_W-1:0] perm);
        pending_req.push_back('{cmd: cmd, va: va, pa: pa, perm: perm});
        if (cmd == CMD_MAP) mapped_va.push_back(va);
    endtask

    // write the pool base, then read it back
    task automatic set_pool_base(input logic [PFN_W-1:0] base);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POOL_BASE_ADDR;
        pwdata  <= {24'b0, base};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pool_base = base;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {24'b0, base}) begin
            $display("%0t pool_base readback exp %h got %h", $time, {24'b0, base}, prdata);
            err_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_req.size() != 0 || i_valid || expected_rsp.size() != 0)
            @(negedge i_clk);
        repeat (32) @(negedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) expected_rsp.push_back(walk_predict(drv_item));
            if (i_valid && !o_ready) begin
                // hold the item until taken
            end else if (req_gap != 0) begin
                i_valid <= 1'b0;
                req_gap <= req_gap - 1;
            end else if (pending_req.size() != 0) begin
                drv_item = pending_req.pop_front();
                i_cmd       <= drv_item.cmd;
                i_virt_addr <= drv_item.va;
                i_phys_addr <= drv_item.pa;
                i_perm      <= drv_item.perm;
                i_valid     <= 1'b1;
                req_gap     <= idle_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_rsp.size() == 0) begin
                    $display("%0t unexpected item: value %h status %0d", $time, o_value, o_status);
                    err_cnt++;
                end else begin
                    if (o_value !== expected_rsp[0].value) begin
                        $display("%0t value exp %h got %h", $time, expected_rsp[0].value,
                                 o_value);
                        err_cnt++;
                    end
                    if (o_status !== expected_rsp[0].status) begin
                        $display("%0t status exp %0d got %0d", $time, expected_rsp[0].status,
                                 o_status);
                        err_cnt++;
                    end
                    void'(expected_rsp.pop_front());
                end
            end
            if (rsp_stall != 0) begin
                i_ready   <= 1'b0;
                rsp_stall <= rsp_stall - 1;
            end else if (o_valid && i_ready) begin
                stall_len = idle_len();
                i_ready   <= (stall_len == 0);
                rsp_stall <= (stall_len != 0) ? stall_len - 1 : 0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [PFN_W-1:0]  base;
        logic [VA_W-1:0]   va;
        logic [PA_W-1:0]   pa;
        logic [PERM_W-1:0] perm;
        int unsigned       sel;
        foreach (page_tables[k]) page_tables[k] = '0;
        next_frame = 1;
        pool_base  = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty root, extreme fields, each allocation depth, pool running out
        add_item(CMD_XLATE, 48'hFFFF_FFFF_FFFF, '0, '0);
        add_item(CMD_XLATE, 48'h0, '1, '1);
        add_item(CMD_MAP,   48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 12'hFFF);
        add_item(CMD_XLATE, 48'hFFFF_FFFF_FFFF, '0, '0);
        add_item(CMD_MAP,   48'hFFFF_FFFF_FFFF, '0, '0);
        add_item(CMD_XLATE, 48'hFFFF_FFFF_F000, '0, '0);
        add_item(CMD_MAP,   48'h0, 52'h0_0000_0000_1000, 12'h001);
        add_item(CMD_XLATE, 48'h0000_0000_0ABC, '0, '0);
        add_item(CMD_MAP,   48'h0000_4000_0000, 52'hA_BCDE_F012_3000, 12'h103);
        add_item(CMD_MAP,   48'h0000_0020_0000, 52'h8_0000_0000_0000, 12'h0FE);
        add_item(CMD_XLATE, 48'h0000_8000_0123, '0, '0);
        add_item(CMD_XLATE, 48'h0000_0040_0000, '0, '0);
        // unaligned physical address: low bits land in the leaf
        add_item(CMD_MAP,   48'h0, 52'h0_0000_1234_5678, 12'h800);
        add_item(CMD_XLATE, 48'h0000_0000_0FFF, '0, '0);
        add_item(CMD_MAP,   48'h0000_0000_1000, 52'h1_2345_6000, PERM_GLOBAL);
        add_item(CMD_XLATE, 48'h0000_0000_1FFF, '0, '0);
        add_item(CMD_MAP,   48'h8000_0000_0000, 52'h5_5555_5555_5000, 12'h555);
        add_item(CMD_MAP,   48'h0000_4020_0000, 52'hA_AAAA_AAAA_A000, 12'hAAA);
        // needs three frames with two left: nothing may be written
        add_item(CMD_MAP,   48'h5555_0000_0000, 52'h0_0000_0000_7000, 12'h007);
        add_item(CMD_XLATE, 48'h5555_0000_0000, '0, '0);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       base = '0;
                1:       base = '1;
                2:       base = PFN_W'({$urandom, $urandom});
                3:       base = PFN_W'(7);
                default: base = '0;
            endcase
            set_pool_base(base);
            no_idle = (ph == 3);
            @(negedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(0, 99);
                if (mapped_va.size() == 0 || sel < 20) begin
                    va = VA_W'({$urandom, $urandom});
                end else begin
                    va = mapped_va[$urandom_range(0, mapped_va.size() - 1)];
                    if (sel < 35)      va[29:21] = IDX_W'($urandom_range(0, 511));
                    else if (sel < 70) va[20:12] = IDX_W'($urandom_range(0, 511));
                    va[11:0] = OFFS_W'($urandom_range(0, 4095));
                end
                pa   = PA_W'({$urandom, $urandom});
                perm = PERM_W'($urandom_range(0, 4095));
                if ($urandom_range(0, 4) != 0) pa[11:0] = '0;
                if ($urandom_range(0, 9) == 0) begin
                    pa   = '0;
                    perm = '0;
                end
                add_item($urandom_range(0, 1) ? CMD_MAP : CMD_XLATE, va, pa, perm);
            end
            wait_idle();
        end

        repeat (32) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
